// ===== src/epoch_ms_to_civil_datetime_core_macros.svh =====
// Assertion macros shared by the epoch-to-civil conversion core.
`ifndef EPOCH_MS_TO_CIVIL_DATETIME_CORE_MACROS_SVH
`define EPOCH_MS_TO_CIVIL_DATETIME_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication under an active-low reset.
`define EM2C_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication under an active-low reset.
`define EM2C_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EM2C_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define EM2C_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/em2c_pkg.sv =====
package em2c_pkg;

  // Number of register stages from request input to result output.
  localparam int unsigned StageCount = 14;

  // Milliseconds per day is 1024 * 84375; the low ten bits pass straight through.
  localparam logic [16:0] DayDivisor = 17'd84375;
  localparam logic [21:0] DayRecip   = 22'((64'd1 << 38) / 64'd84375);

  // Calendar constants for the March-based day count.
  localparam logic [21:0] DaysTo0301     = 22'd719468;
  localparam logic [17:0] DaysPerEra     = 18'd146097;
  localparam logic [4:0]  EraRecip       = 5'((64'd1 << 22) / 64'd146097);
  localparam logic [15:0] DaysPerCentury = 16'd36524;
  localparam logic [10:0] DaysPerQuad    = 11'd1461;
  localparam logic [5:0]  QuadRecip      = 6'((64'd1 << 16) / 64'd1461);
  localparam logic [8:0]  DaysPerYear    = 9'd365;

  localparam logic [8:0] YearsPerEra     = 9'd400;
  localparam logic [6:0] YearsPerCentury = 7'd100;
  localparam logic [2:0] YearsPerQuad    = 3'd4;

  // Time-of-day constants.
  localparam logic [9:0]  MsPerSec   = 10'd1000;
  localparam logic [17:0] SecRecip   = 18'((64'd1 << 27) / 64'd1000);
  localparam logic [11:0] SecPerHour = 12'd3600;
  localparam logic [5:0]  HourRecip  = 6'((64'd1 << 17) / 64'd3600);
  localparam logic [5:0]  SecPerMin  = 6'd60;
  localparam logic [6:0]  MinRecip   = 7'((64'd1 << 12) / 64'd60);

  // Month index codes within the March-based year.
  localparam logic [3:0] JanIdx        = 4'd10;
  localparam logic [3:0] LastIdx       = 4'd11;
  localparam logic [3:0] MarchMonth    = 4'd3;
  localparam logic [3:0] MonthsPerYear = 4'd12;

  // First day of each month, counted from the first of March.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] start;
    unique case (idx)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

// ===== src/epoch_ms_to_civil_datetime_core.sv =====
// Converts a count of milliseconds since 1970-01-01 00:00:00.000 into the
// proleptic Gregorian year, month, day, hour, minute, second and millisecond.
// The request channel carries epoch_ms_i under in_valid_i / in_stall_o; the
// result channel carries the seven calendar fields under out_valid_o /
// out_stall_i. A transfer happens on a rising edge with valid high and stall low.
// Each request gives exactly one result, in order.
// The core is a 14-stage pipeline, and one request can be taken in every
// cycle while in_stall_o is low. The depth is set by the chain of constant
// divisions (days, eras, quads; seconds, hours, minutes), each done as a
// reciprocal multiply, a multiply-back and a one-step correction in stages
// of their own.
// A stalled result holds its fields; empty stages still move up behind it, so
// requests keep being taken until every stage is full, and only then is
// in_stall_o raised.
// Reset clears all valid bits; no result is pending after reset.
`include "epoch_ms_to_civil_datetime_core_macros.svh"

module epoch_ms_to_civil_datetime_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [47:0] epoch_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [9:0]  millisecond_o
);
  import em2c_pkg::*;

  // Stage valid bits and per-stage advance enables.
  logic [StageCount-1:0] vld_q, vld_d, adv;

  // A stage moves on when it is empty or the stage after it moves on.
  always_comb begin
    adv[StageCount-1] = !vld_q[StageCount-1] || !out_stall_i;
    for (int k = StageCount - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < StageCount; k++) begin
      if (k == 0) begin
        vld_d[k] = adv[k] ? in_valid_i : vld_q[k];
      end else begin
        vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[StageCount-1];

  // Stage 1: partial products of (ms / 1024) times the day reciprocal.
  logic [53:0] s1_plo_q;
  logic [27:0] s1_phi_q;
  logic [27:0] s1_low_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_plo_q <= 54'(epoch_ms_i[41:10]) * 54'(DayRecip);
      s1_phi_q <= 28'(epoch_ms_i[47:42]) * 28'(DayRecip);
      s1_low_q <= epoch_ms_i[27:0];
    end
  end

  // Stage 2: combine the partial products into the day count estimate.
  logic [59:0] s2_sum;
  logic [21:0] s2_q0_q;
  logic [27:0] s2_low_q;

  assign s2_sum = {s1_phi_q, 32'd0} + {6'd0, s1_plo_q};

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_q0_q  <= s2_sum[59:38];
      s2_low_q <= s1_low_q;
    end
  end

  // Stage 3: remainder of the estimate; only its low bits are needed.
  logic [21:0] s3_prod;
  logic [21:0] s3_q0_q;
  logic [17:0] s3_r_q;
  logic [9:0]  s3_ms_q;

  assign s3_prod = s2_q0_q * 22'(DayDivisor);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_q0_q <= s2_q0_q;
      s3_r_q  <= s2_low_q[27:10] - s3_prod[17:0];
      s3_ms_q <= s2_low_q[9:0];
    end
  end

  // Stage 4: correct the day count, rebase it to 0000-03-01 and form ms of day.
  logic        s4_fix;
  logic [17:0] s4_rem;
  logic [21:0] s4_dnum_q;
  logic [26:0] s4_msd_q;

  assign s4_fix = s3_r_q >= 18'(DayDivisor);
  assign s4_rem = s3_r_q - (s4_fix ? 18'(DayDivisor) : 18'd0);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_dnum_q <= s3_q0_q + (s4_fix ? DaysTo0301 + 22'd1 : DaysTo0301);
      s4_msd_q  <= {s4_rem[16:0], s3_ms_q};
    end
  end

  // Stage 5: estimates of the era and of the second of the day.
  logic [26:0] s5_eprod;
  logic [44:0] s5_sprod;
  logic [4:0]  s5_eq_q;
  logic [16:0] s5_sq_q;
  logic [21:0] s5_dnum_q;
  logic [26:0] s5_msd_q;

  assign s5_eprod = 27'(s4_dnum_q) * 27'(EraRecip);
  assign s5_sprod = 45'(s4_msd_q) * 45'(SecRecip);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s5_eq_q   <= s5_eprod[26:22];
      s5_sq_q   <= s5_sprod[43:27];
      s5_dnum_q <= s4_dnum_q;
      s5_msd_q  <= s4_msd_q;
    end
  end

  // Stage 6: remainders of both estimates.
  logic [18:0] s6_eback;
  logic [10:0] s6_sback;
  logic [4:0]  s6_eq_q;
  logic [16:0] s6_sq_q;
  logic [18:0] s6_er_q;
  logic [10:0] s6_sr_q;

  assign s6_eback = 19'(s5_eq_q) * 19'(DaysPerEra);
  assign s6_sback = 11'(s5_sq_q) * 11'(MsPerSec);

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s6_eq_q <= s5_eq_q;
      s6_sq_q <= s5_sq_q;
      s6_er_q <= s5_dnum_q[18:0] - s6_eback;
      s6_sr_q <= s5_msd_q[10:0] - s6_sback;
    end
  end

  // Stage 7: correct era / day of era and second of day / millisecond.
  logic        s7_efix, s7_sfix;
  logic [4:0]  s7_era_q;
  logic [17:0] s7_doe_q;
  logic [16:0] s7_sod_q;
  logic [9:0]  s7_milli_q;

  assign s7_efix = s6_er_q >= 19'(DaysPerEra);
  assign s7_sfix = s6_sr_q >= 11'(MsPerSec);

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s7_era_q   <= s6_eq_q + 5'(s7_efix);
      s7_doe_q   <= 18'(s6_er_q - (s7_efix ? 19'(DaysPerEra) : 19'd0));
      s7_sod_q   <= s6_sq_q + 17'(s7_sfix);
      s7_milli_q <= 10'(s6_sr_q - (s7_sfix ? 11'(MsPerSec) : 11'd0));
    end
  end

  // Stage 8: century of the era, clamped to three; hour estimate.
  logic [1:0]  s8_cen;
  logic [17:0] s8_cbase;
  logic [22:0] s8_hprod;
  logic [1:0]  s8_cen_q;
  logic [15:0] s8_doe2_q;
  logic [4:0]  s8_hq_q;
  logic [16:0] s8_sod_q;
  logic [4:0]  s8_era_q;
  logic [9:0]  s8_milli_q;

  always_comb begin
    s8_cen = 2'd0;
    if (s7_doe_q >= 18'(DaysPerCentury)) begin
      s8_cen = 2'd1;
    end
    if (s7_doe_q >= 18'(DaysPerCentury) * 18'd2) begin
      s8_cen = 2'd2;
    end
    if (s7_doe_q >= 18'(DaysPerCentury) * 18'd3) begin
      s8_cen = 2'd3;
    end
  end

  assign s8_cbase = 18'(s8_cen) * 18'(DaysPerCentury);
  assign s8_hprod = 23'(s7_sod_q) * 23'(HourRecip);

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      s8_cen_q   <= s8_cen;
      s8_doe2_q  <= 16'(s7_doe_q - s8_cbase);
      s8_hq_q    <= s8_hprod[21:17];
      s8_sod_q   <= s7_sod_q;
      s8_era_q   <= s7_era_q;
      s8_milli_q <= s7_milli_q;
    end
  end

  // Stage 9: quad estimate; hour remainder.
  logic [21:0] s9_qprod;
  logic [12:0] s9_hback;
  logic [4:0]  s9_qq_q;
  logic [15:0] s9_doe2_q;
  logic [4:0]  s9_hq_q;
  logic [12:0] s9_hr_q;
  logic [4:0]  s9_era_q;
  logic [1:0]  s9_cen_q;
  logic [9:0]  s9_milli_q;

  assign s9_qprod = 22'(s8_doe2_q) * 22'(QuadRecip);
  assign s9_hback = 13'(s8_hq_q) * 13'(SecPerHour);

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      s9_qq_q    <= s9_qprod[20:16];
      s9_doe2_q  <= s8_doe2_q;
      s9_hq_q    <= s8_hq_q;
      s9_hr_q    <= s8_sod_q[12:0] - s9_hback;
      s9_era_q   <= s8_era_q;
      s9_cen_q   <= s8_cen_q;
      s9_milli_q <= s8_milli_q;
    end
  end

  // Stage 10: quad remainder; corrected hour and second of hour.
  logic [11:0] s10_qback;
  logic        s10_hfix;
  logic [4:0]  s10_qq_q;
  logic [11:0] s10_qr_q;
  logic [4:0]  s10_hour_q;
  logic [11:0] s10_rem_q;
  logic [4:0]  s10_era_q;
  logic [1:0]  s10_cen_q;
  logic [9:0]  s10_milli_q;

  assign s10_qback = 12'(s9_qq_q) * 12'(DaysPerQuad);
  assign s10_hfix  = s9_hr_q >= 13'(SecPerHour);

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      s10_qq_q    <= s9_qq_q;
      s10_qr_q    <= s9_doe2_q[11:0] - s10_qback;
      s10_hour_q  <= s9_hq_q + 5'(s10_hfix);
      s10_rem_q   <= 12'(s9_hr_q - (s10_hfix ? 13'(SecPerHour) : 13'd0));
      s10_era_q   <= s9_era_q;
      s10_cen_q   <= s9_cen_q;
      s10_milli_q <= s9_milli_q;
    end
  end

  // Stage 11: corrected quad and day of quad; minute estimate.
  logic        s11_qfix;
  logic [18:0] s11_mprod;
  logic [4:0]  s11_quad_q;
  logic [10:0] s11_d3_q;
  logic [5:0]  s11_mq_q;
  logic [11:0] s11_rem_q;
  logic [4:0]  s11_era_q;
  logic [1:0]  s11_cen_q;
  logic [4:0]  s11_hour_q;
  logic [9:0]  s11_milli_q;

  assign s11_qfix  = s10_qr_q >= 12'(DaysPerQuad);
  assign s11_mprod = 19'(s10_rem_q) * 19'(MinRecip);

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      s11_quad_q  <= s10_qq_q + 5'(s11_qfix);
      s11_d3_q    <= 11'(s10_qr_q - (s11_qfix ? 12'(DaysPerQuad) : 12'd0));
      s11_mq_q    <= s11_mprod[17:12];
      s11_rem_q   <= s10_rem_q;
      s11_era_q   <= s10_era_q;
      s11_cen_q   <= s10_cen_q;
      s11_hour_q  <= s10_hour_q;
      s11_milli_q <= s10_milli_q;
    end
  end

  // Stage 12: year of quad, clamped to three, and day of year; minute remainder.
  logic [1:0]  s12_yi;
  logic [6:0]  s12_mback;
  logic [1:0]  s12_yi_q;
  logic [8:0]  s12_doy_q;
  logic [13:0] s12_ybase_q;
  logic [4:0]  s12_quad_q;
  logic [5:0]  s12_mq_q;
  logic [6:0]  s12_mr_q;
  logic [4:0]  s12_hour_q;
  logic [9:0]  s12_milli_q;

  always_comb begin
    s12_yi = 2'd0;
    if (s11_d3_q >= 11'(DaysPerYear)) begin
      s12_yi = 2'd1;
    end
    if (s11_d3_q >= 11'(DaysPerYear) * 11'd2) begin
      s12_yi = 2'd2;
    end
    if (s11_d3_q >= 11'(DaysPerYear) * 11'd3) begin
      s12_yi = 2'd3;
    end
  end

  assign s12_mback = 7'(s11_mq_q) * 7'(SecPerMin);

  always_ff @(posedge clk_i) begin
    if (adv[11]) begin
      s12_yi_q    <= s12_yi;
      s12_doy_q   <= 9'(s11_d3_q - 11'(s12_yi) * 11'(DaysPerYear));
      s12_ybase_q <= 14'(s11_era_q) * 14'(YearsPerEra)
                   + 14'(s11_cen_q) * 14'(YearsPerCentury);
      s12_quad_q  <= s11_quad_q;
      s12_mq_q    <= s11_mq_q;
      s12_mr_q    <= s11_rem_q[6:0] - s12_mback;
      s12_hour_q  <= s11_hour_q;
      s12_milli_q <= s11_milli_q;
    end
  end

  // Stage 13: month index from the table of month starts; corrected minute.
  logic [3:0]  s13_midx;
  logic        s13_mfix;
  logic [3:0]  s13_midx_q;
  logic [8:0]  s13_doy_q;
  logic [13:0] s13_year_q;
  logic [4:0]  s13_hour_q;
  logic [5:0]  s13_minute_q;
  logic [5:0]  s13_second_q;
  logic [9:0]  s13_milli_q;

  always_comb begin
    s13_midx = 4'd0;
    for (int i = 1; i <= int'(LastIdx); i++) begin
      if (s12_doy_q >= month_start(4'(i))) begin
        s13_midx = 4'(i);
      end
    end
  end

  assign s13_mfix = s12_mr_q >= 7'(SecPerMin);

  always_ff @(posedge clk_i) begin
    if (adv[12]) begin
      s13_midx_q   <= s13_midx;
      s13_doy_q    <= s12_doy_q;
      s13_year_q   <= s12_ybase_q + 14'(s12_quad_q) * 14'(YearsPerQuad) + 14'(s12_yi_q);
      s13_hour_q   <= s12_hour_q;
      s13_minute_q <= s12_mq_q + 6'(s13_mfix);
      s13_second_q <= 6'(s12_mr_q - (s13_mfix ? 7'(SecPerMin) : 7'd0));
      s13_milli_q  <= s12_milli_q;
    end
  end

  // Stage 14: output register; January and February belong to the next year.
  logic        s14_jan;
  logic [13:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;
  logic [9:0]  milli_q;

  assign s14_jan = s13_midx_q >= JanIdx;

  always_ff @(posedge clk_i) begin
    if (adv[13]) begin
      year_q   <= s13_year_q + 14'(s14_jan);
      month_q  <= s14_jan ? s13_midx_q + MarchMonth - MonthsPerYear
                          : s13_midx_q + MarchMonth;
      day_q    <= 5'(s13_doy_q - month_start(s13_midx_q) + 9'd1);
      hour_q   <= s13_hour_q;
      minute_q <= s13_minute_q;
      second_q <= s13_second_q;
      milli_q  <= s13_milli_q;
    end
  end

  assign year_o        = year_q;
  assign month_o       = month_q;
  assign day_o         = day_q;
  assign hour_o        = hour_q;
  assign minute_o      = minute_q;
  assign second_o      = second_q;
  assign millisecond_o = milli_q;

  // A taken request always lands in the first stage.
  `EM2C_ASSERT_NXT(a_accept_fills, clk_i, rst_ni, in_valid_i && !in_stall_o, vld_q[0], "request lost at entry")
  // Requests are refused only when every stage holds an item.
  `EM2C_ASSERT_IMP(a_stall_full, clk_i, rst_ni, in_stall_o, &vld_q, "stall raised with an empty stage")
  // Every divider correction leaves its field in range.
  `EM2C_ASSERT_IMP(a_out_range, clk_i, rst_ni, out_valid_o, month_o >= 4'd1 && month_o <= 4'd12 && day_o >= 5'd1 && hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59 && millisecond_o <= 10'd999, "result field out of range")
  // February never runs past the leap day.
  `EM2C_ASSERT_IMP(a_feb_len, clk_i, rst_ni, out_valid_o && month_o == 4'd2, day_o <= 5'd29, "February day out of range")

endmodule
